[design/gecal_pkg.sv]
// Shared types, constants and month table for the Gregorian Easter / year calendar.
// No dependencies; used by every other file of the block except gecal_if.
package gecal_pkg;

	// supported year range, inputs outside are clamped
	localparam logic [13:0] YEAR_MIN = 14'd1583;
	localparam logic [13:0] YEAR_MAX = 14'd9999;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// month codes
	localparam logic [3:0] MONTH_JAN = 4'd0;
	localparam logic [3:0] MONTH_FEB = 4'd1;
	localparam logic [3:0] MONTH_APR = 4'd3;
	localparam logic [3:0] MONTH_JUN = 4'd5;
	localparam logic [3:0] MONTH_SEP = 4'd8;
	localparam logic [3:0] MONTH_NOV = 4'd10;
	localparam logic [3:0] MONTH_DEC = 4'd11;

	// Easter month codes
	localparam logic [2:0] EASTER_MARCH = 3'd3;
	localparam logic [2:0] EASTER_APRIL = 3'd4;

	// per-year result handed from front to back
	typedef struct packed {
		logic [2:0] jan_weekday;
		logic       leap;
		logic [2:0] easter_month;
		logic [4:0] easter_day;
	} gecal_year_t;

	// days in a month
	function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
		logic [4:0] len;
		unique case (idx)
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

[design/gecal_if.sv]
// Handshake channels of the calendar block: year requests in, month records out.
// Depends on nothing; payload widths are fixed by the field definitions.
interface gecal_year_if;
	logic        valid;
	logic        ready;
	logic [13:0] year;

	modport source(output valid, output year, input ready);
	modport sink(input valid, input year, output ready);
endinterface

interface gecal_month_if;
	logic       valid;
	logic       ready;
	logic [3:0] month_index;
	logic [2:0] first_weekday;
	logic [4:0] month_length;
	logic       leap_year;
	logic [2:0] easter_month;
	logic [4:0] easter_day;
	logic       last_month;

	modport source(output valid, output month_index, output first_weekday,
		output month_length, output leap_year, output easter_month,
		output easter_day, output last_month, input ready);
	modport sink(input valid, input month_index, input first_weekday,
		input month_length, input leap_year, input easter_month,
		input easter_day, input last_month, output ready);
endinterface

[design/gecal_front.sv]
// Front part: takes year requests, runs the computus pipeline, writes the queue.
// Depends on gecal_pkg and gecal_year_if.
module gecal_front #(
	parameter int DEPTH = gecal_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	gecal_year_if.sink             years,
	input  logic                   credit_ret,
	output logic                   wr_valid,
	output gecal_pkg::gecal_year_t wr_data
);

	localparam int CW = $clog2(DEPTH + 1);

	// reciprocals for constant division, exact over the operand ranges used
	localparam logic [13:0] RECIP19  = 14'd13798; // >> 18
	localparam logic [12:0] RECIP100 = 13'd5243;  // >> 19
	localparam logic [10:0] RECIP25  = 11'd1311;  // >> 15
	localparam logic [9:0]  RECIP30  = 10'd547;   // >> 14
	localparam logic [14:0] RECIP7   = 15'd18725; // >> 17
	localparam logic [7:0]  RECIP7S  = 8'd147;    // >> 10, small operands

	logic [CW-1:0] credit_q;
	logic          accept;

	assign years.ready = (credit_q != '0);
	assign accept      = years.valid && years.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CW'(DEPTH);
		end else begin
			credit_q <= credit_q - CW'(accept) + CW'(credit_ret);
		end
	end

	// clamp
	logic [13:0] ysat;
	always_comb begin
		if (years.year < gecal_pkg::YEAR_MIN) ysat = gecal_pkg::YEAR_MIN;
		else if (years.year > gecal_pkg::YEAR_MAX) ysat = gecal_pkg::YEAR_MAX;
		else ysat = years.year;
	end

	logic [7:1] vld_q;

	// s1
	logic [13:0] y_s1;
	// s2
	logic [13:0] y_s2;
	logic [9:0]  q19_s2;
	logic [6:0]  c0_s2;
	// s3
	logic [13:0] y_s3;
	logic [4:0]  g_s3;
	logic [5:0]  x_s3;
	logic [9:0]  t_s3;
	logic        leap_s3;
	// s4
	logic [4:0]  g_s4;
	logic [8:0]  v_s4;
	logic [13:0] d_s4;
	logic        leap_s4;
	// s5
	logic [5:0]  n_s5;
	logic [13:0] d_s5;
	logic        leap_s5;
	// s6
	logic [5:0]  n_s6;
	logic        leap_s6;
	// s7
	gecal_pkg::gecal_year_t res_s7;

	// s2 logic
	logic [27:0] p19;
	logic [26:0] p100;
	assign p19  = 28'(y_s1) * 28'(RECIP19);
	assign p100 = 27'(y_s1) * 27'(RECIP100);

	// s3 logic
	logic [13:0] r19, r100;
	logic [6:0]  c;
	logic [8:0]  c3;
	assign r19  = y_s2 - 14'(q19_s2) * 14'd19;
	assign r100 = y_s2 - 14'(c0_s2) * 14'd100;
	assign c    = c0_s2 + 7'd1;
	assign c3   = 9'(c) * 9'd3;

	// s4 logic
	logic [20:0] p25;
	logic [4:0]  z;
	logic [15:0] y5;
	assign p25 = 21'(t_s3) * 21'(RECIP25);
	assign z   = 5'(p25[20:15]) - 5'd5;
	assign y5  = 16'(y_s3) * 16'd5;

	// s5 logic: epact and paschal full moon
	logic [17:0] p30;
	logic [4:0]  e_raw, e_adj;
	logic [5:0]  n_raw;
	assign p30   = 18'(v_s4) * 18'(RECIP30);
	assign e_raw = 5'(v_s4 - 9'(p30[17:14]) * 9'd30);
	always_comb begin
		e_adj = e_raw;
		if (e_raw == 5'd24 || (e_raw == 5'd25 && g_s4 > 5'd11)) e_adj = e_raw + 5'd1;
		n_raw = 6'd44 - 6'(e_adj);
		if (n_raw < 6'd21) n_raw = n_raw + 6'd30;
	end

	// s6 logic: advance to Sunday
	logic [13:0] s7sum;
	logic [27:0] p7;
	logic [2:0]  r7;
	assign s7sum = d_s5 + 14'(n_s5);
	assign p7    = 28'(s7sum) * 28'(RECIP7);
	assign r7    = 3'(s7sum - 14'(p7[27:17]) * 14'd7);

	// s7 logic: Easter date and weekday of 1 January
	logic [6:0]  doy;
	logic [6:0]  w;
	logic [14:0] pw;
	logic [2:0]  wd_jan;
	assign doy    = 7'd59 + 7'(leap_s6) + 7'(n_s6);
	assign w      = 7'd127 - doy;
	assign pw     = 15'(w) * 15'(RECIP7S);
	assign wd_jan = 3'(w - 7'(pw[14:10]) * 7'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[6:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		y_s1    <= ysat;

		y_s2    <= y_s1;
		q19_s2  <= p19[27:18];
		c0_s2   <= p100[25:19];

		y_s3    <= y_s2;
		g_s3    <= 5'(r19) + 5'd1;
		x_s3    <= 6'(c3[8:2] - 7'd12);
		t_s3    <= 10'(c) * 10'd8 + 10'd5;
		leap_s3 <= (y_s2[1:0] == 2'b00) && ((r100 != '0) || (c0_s2[1:0] == 2'b00));

		g_s4    <= g_s3;
		v_s4    <= 9'(g_s3) * 9'd11 + 9'd80 + 9'(z) - 9'(x_s3);
		d_s4    <= 14'(y5[15:2]) - 14'(x_s3) - 14'd10;
		leap_s4 <= leap_s3;

		n_s5    <= n_raw;
		d_s5    <= d_s4;
		leap_s5 <= leap_s4;

		n_s6    <= n_s5 + 6'd7 - 6'(r7);
		leap_s6 <= leap_s5;

		res_s7.jan_weekday <= wd_jan;
		res_s7.leap        <= leap_s6;
		if (n_s6 > 6'd31) begin
			res_s7.easter_month <= gecal_pkg::EASTER_APRIL;
			res_s7.easter_day   <= 5'(n_s6 - 6'd31);
		end else begin
			res_s7.easter_month <= gecal_pkg::EASTER_MARCH;
			res_s7.easter_day   <= 5'(n_s6);
		end
	end

	assign wr_valid = vld_q[7];
	assign wr_data  = res_s7;

endmodule

[design/gecal_queue.sv]
// Short FIFO of per-year results between the front and back parts.
// Depends on gecal_pkg; the writer never exceeds DEPTH entries.
module gecal_queue #(
	parameter int DEPTH = gecal_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_valid,
	input  gecal_pkg::gecal_year_t wr_data,
	output logic                   rd_valid,
	output gecal_pkg::gecal_year_t rd_data,
	input  logic                   rd_pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gecal_pkg::gecal_year_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_pop   = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(wr_valid) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

[design/gecal_back.sv]
// Back part: expands one per-year result into twelve month records.
// Depends on gecal_pkg and gecal_month_if.
module gecal_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  gecal_pkg::gecal_year_t q_data,
	output logic                   q_pop,
	gecal_month_if.source          months
);

	logic                   busy_q;
	logic [3:0]             month_q;
	logic [2:0]             wd_q;
	gecal_pkg::gecal_year_t cur_q;
	logic                   out_valid_q;

	logic       out_free, emit, is_last;
	logic [4:0] len;
	logic [3:0] wd_sum;
	logic [2:0] wd_next;

	assign out_free = !out_valid_q || months.ready;
	assign emit     = busy_q && out_free;
	assign is_last  = (month_q == gecal_pkg::MONTH_DEC);
	assign q_pop    = q_valid && (!busy_q || (emit && is_last));
	assign len      = gecal_pkg::month_days(month_q, cur_q.leap);

	// len mod 7 is len - 28
	always_comb begin
		wd_sum  = 4'(wd_q) + 4'(len - 5'd28);
		wd_next = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : 3'(wd_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) busy_q <= 1'b1;
			else if (emit && is_last) busy_q <= 1'b0;

			if (emit) out_valid_q <= 1'b1;
			else if (months.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q   <= q_data;
			month_q <= gecal_pkg::MONTH_JAN;
			wd_q    <= q_data.jan_weekday;
		end else if (emit) begin
			month_q <= month_q + 4'd1;
			wd_q    <= wd_next;
		end

		if (emit) begin
			months.month_index   <= month_q;
			months.first_weekday <= wd_q;
			months.month_length  <= len;
			months.leap_year     <= cur_q.leap;
			months.easter_month  <= cur_q.easter_month;
			months.easter_day    <= cur_q.easter_day;
			months.last_month    <= is_last;
		end
	end

	assign months.valid = out_valid_q;

endmodule

[design/gregorian_easter_year_calendar.sv]
// Gregorian Easter / year calendar, top level. With the block idle, the first month
// record of a year passes through the seven front stages, the queue, the back part's
// year register and its output register. Throughput is set by the back part, which
// sends one month record per cycle while the receiver is ready; the front pipeline
// takes a year every cycle while queue credit lasts. Reset (arst_n, async, active low)
// clears all control state at once; no clearing pass, the block is ready on release.
module gregorian_easter_year_calendar #(
	parameter int QUEUE_DEPTH = gecal_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	gecal_year_if.sink    years,
	gecal_month_if.source months
);

	// Front -> queue: computed Easter date, leap flag and weekday of 1 January.
	logic                   wr_valid;
	gecal_pkg::gecal_year_t wr_data;

	// Queue -> back; a pop also returns one credit to the front, so the
	// front never has more years in flight than the queue can hold.
	logic                   rd_valid;
	gecal_pkg::gecal_year_t rd_data;
	logic                   rd_pop;

	// Front: clamps the year, then a seven-stage computus pipeline
	// (golden number, century, epact, Sunday search, January weekday).
	gecal_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.years     (years),
		.credit_ret(rd_pop),
		.wr_valid  (wr_valid),
		.wr_data   (wr_data)
	);

	// Short FIFO decoupling the pipeline from the record sequencer.
	gecal_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(wr_valid),
		.wr_data (wr_data),
		.rd_valid(rd_valid),
		.rd_data (rd_data),
		.rd_pop  (rd_pop)
	);

	// Back: walks January to December, carries the weekday forward by month
	// length and holds each record in an output register until taken. The
	// next year is loaded while December goes out, so records flow gap-free.
	gecal_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(rd_valid),
		.q_data (rd_data),
		.q_pop  (rd_pop),
		.months (months)
	);

endmodule

[sim/gregorian_easter_year_calendar_tb.sv]
// Self-checking testbench for gregorian_easter_year_calendar: years in, twelve month records out.
// Depends on gecal_pkg, the gecal_year_if / gecal_month_if channels and the block's top level.
// Month records are predicted in-bench and checked in order, under random stalls on both sides.
module gregorian_easter_year_calendar_tb;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 6;
	localparam int RANDOM_YEARS  = 400;
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
	localparam int DRAIN_CYCLES  = 20;    // margin after the last expected record
	localparam int WATCHDOG_MAX  = 3000;  // idle cycles with no request moving

	// one month record as it leaves the block
	typedef struct packed {
		logic [3:0] month_index;
		logic [2:0] first_weekday;
		logic [4:0] month_length;
		logic       leap_year;
		logic [2:0] easter_month;
		logic [4:0] easter_day;
		logic       last_month;
	} month_rec_t;

	logic clk;
	logic arst_n;

	gecal_year_if  years_ch();
	gecal_month_if months_ch();

	gregorian_easter_year_calendar u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.years  (years_ch),
		.months (months_ch)
	);

	// records still owed by the block, oldest first
	month_rec_t expected_months[$];
	int         error_count;
	int         idle_cycles;

	// idling knobs: gap modes switch so some stretches run with no idling at all
	bit         year_gaps_on;
	bit         month_stalls_on;
	bit         hold_req;
	int         hold_left;
	int         stall_left;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// modulo that stays non-negative for negative left operands
	function automatic int wrap_mod(input int v, input int m);
		int r;
		r = v % m;
		return (r < 0) ? r + m : r;
	endfunction

	// Computus for one year, then the twelve month records it produces.
	task automatic predict_year_months(input logic [13:0] raw_year);
		int         y, golden, century, skip, moon_corr, epact, pfm, dom;
		int         e_day, doy, wday, len;
		logic       leap;
		logic [2:0] e_month;
		month_rec_t rec;
		int         days_in_month[12];
		days_in_month = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		// out-of-range years are clamped, not rejected
		y = int'(raw_year);
		if (y < int'(gecal_pkg::YEAR_MIN)) y = int'(gecal_pkg::YEAR_MIN);
		if (y > int'(gecal_pkg::YEAR_MAX)) y = int'(gecal_pkg::YEAR_MAX);

		golden    = (y % 19) + 1;
		century   = (y / 100) + 1;
		skip      = (3 * century) / 4 - 12;        // dropped leap days
		moon_corr = (8 * century + 5) / 25 - 5;    // lunar orbit correction
		epact     = wrap_mod(11 * golden + 20 + moon_corr - skip, 30);
		// epact bump: 24 always, 25 only late in the Metonic cycle
		if ((epact == 25 && golden > 11) || epact == 24) epact++;
		pfm = 44 - epact;                          // paschal full moon, March days
		if (pfm < 21) pfm += 30;
		dom = (5 * y) / 4 - (skip + 10);           // Sunday finder
		pfm = pfm + 7 - wrap_mod(dom + pfm, 7);
		if (pfm > 31) begin
			e_month = gecal_pkg::EASTER_APRIL;
			e_day   = pfm - 31;
		end else begin
			e_month = gecal_pkg::EASTER_MARCH;
			e_day   = pfm;
		end

		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);

		// count back from Easter Sunday to 1 January
		doy  = 59 + int'(leap) + e_day + ((e_month == gecal_pkg::EASTER_APRIL) ? 31 : 0);
		wday = wrap_mod(1 - doy, 7);

		for (int m = 0; m < 12; m++) begin
			len = days_in_month[m] + ((m == int'(gecal_pkg::MONTH_FEB)) ? int'(leap) : 0);
			rec.month_index   = 4'(m);
			rec.first_weekday = 3'(wday);
			rec.month_length  = 5'(len);
			rec.leap_year     = leap;
			rec.easter_month  = e_month;
			rec.easter_day    = 5'(e_day);
			rec.last_month    = (m == int'(gecal_pkg::MONTH_DEC));
			expected_months.push_back(rec);
			wday = (wday + len) % 7;
		end
	endtask

	// Offer one year request and hold it until taken; predict on acceptance.
	task automatic send_year(input logic [13:0] yr);
		int gap;
		gap = year_gaps_on ? pick_delay() : 0;
		if (gap > 0) begin
			years_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		years_ch.valid <= 1'b1;
		years_ch.year  <= yr;
		do @(posedge clk); while (!years_ch.ready);
		predict_year_months(yr);
	endtask

	function automatic bit field_ok(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: month record %s mismatch: expected %0d, actual %0d",
				$time, name, exp_v, act_v);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Checker: every accepted month record against the oldest prediction.
	always @(posedge clk) begin
		month_rec_t exp_rec;
		bit         ok;
		if (arst_n && months_ch.valid && months_ch.ready) begin
			if (expected_months.size() == 0) begin
				$display("%0t: unexpected month record, expected none, actual month %0d year-leap %0d",
					$time, months_ch.month_index, months_ch.leap_year);
				error_count++;
			end else begin
				exp_rec = expected_months.pop_front();
				ok = 1'b1;
				ok &= field_ok("month_index", exp_rec.month_index, months_ch.month_index);
				ok &= field_ok("first_weekday", exp_rec.first_weekday,
					months_ch.first_weekday);
				ok &= field_ok("month_length", exp_rec.month_length, months_ch.month_length);
				ok &= field_ok("leap_year", exp_rec.leap_year, months_ch.leap_year);
				ok &= field_ok("easter_month", exp_rec.easter_month, months_ch.easter_month);
				ok &= field_ok("easter_day", exp_rec.easter_day, months_ch.easter_day);
				ok &= field_ok("last_month", exp_rec.last_month, months_ch.last_month);
				if (!ok) error_count++;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			months_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			months_ch.ready <= 1'b0;
		end else if (month_stalls_on && $urandom_range(0, 99) < 25) begin
			stall_left = pick_delay();
			months_ch.ready <= (stall_left == 0);
		end else begin
			months_ch.ready <= 1'b1;
		end
	end

	// Watchdog: any cycle with no request moving on either side counts.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((years_ch.valid && years_ch.ready) || (months_ch.valid && months_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("%0t: watchdog expired, %0d month records outstanding",
					$time, expected_months.size());
				$display("gregorian_easter_year_calendar_tb: FAIL");
				$finish;
			end
		end
	end

	// Clamping at both ends, plus stray high bits of the year field.
	task automatic test_range_clamping();
		send_year(14'd0);
		send_year(14'd1);
		send_year(14'd1582);
		send_year(gecal_pkg::YEAR_MIN);
		send_year(gecal_pkg::YEAR_MAX);
		send_year(14'd10000);
		send_year(14'd16383);
		send_year(14'd8192);
	endtask

	// Leap rule: plain fours, centuries, and the 400-year exception.
	task automatic test_leap_rules();
		send_year(14'd1600);
		send_year(14'd1700);
		send_year(14'd1900);
		send_year(14'd2000);
		send_year(14'd2023);
		send_year(14'd2024);
		send_year(14'd2100);
		send_year(14'd2400);
	endtask

	// Years that land on the epact bump (epact 24, or 25 with a late golden number).
	task automatic test_epact_correction();
		send_year(14'd1954);
		send_year(14'd1981);
		send_year(14'd2049);
		send_year(14'd2076);
		send_year(14'd2106);
	endtask

	// Random years, mostly in range, some over the whole 14-bit field.
	task automatic test_random_years();
		int         r;
		logic [13:0] yr;
		for (int i = 0; i < RANDOM_YEARS; i++) begin
			// flip idling modes now and then so some stretches run flat out
			if (i % 50 == 0) begin
				year_gaps_on    = $urandom_range(0, 3) != 0;
				month_stalls_on = $urandom_range(0, 3) != 0;
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				yr = 14'($urandom_range(int'(gecal_pkg::YEAR_MIN), int'(gecal_pkg::YEAR_MAX)));
			end else if (r < 90) begin
				yr = 14'($urandom_range(0, 16383));
			end else begin
				// century edges
				yr = 14'($urandom_range(16, 99) * 100 + $urandom_range(0, 1));
			end
			send_year(yr);
		end
	endtask

	// Receiver holds off for a long stretch while years keep coming back to back.
	task automatic test_output_backpressure();
		hold_req     = 1'b1;
		year_gaps_on = 1'b0;
		for (int i = 0; i < 16; i++) begin
			send_year(14'($urandom_range(int'(gecal_pkg::YEAR_MIN),
				int'(gecal_pkg::YEAR_MAX))));
		end
		year_gaps_on = 1'b1;
	endtask

	initial begin
		error_count     = 0;
		idle_cycles     = 0;
		hold_req        = 1'b0;
		hold_left       = 0;
		stall_left      = 0;
		year_gaps_on    = 1'b1;
		month_stalls_on = 1'b1;
		arst_n          = 1'b0;
		years_ch.valid  = 1'b0;
		years_ch.year   = '0;
		months_ch.ready = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_range_clamping();
		test_leap_rules();
		test_epact_correction();
		test_output_backpressure();
		test_random_years();

		years_ch.valid <= 1'b0;
		month_stalls_on = 1'b1;

		// drain; the watchdog bounds this wait
		while (expected_months.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("gregorian_easter_year_calendar_tb: PASS");
		end else begin
			$display("gregorian_easter_year_calendar_tb: FAIL");
		end
		$finish;
	end

endmodule

[gregorian_easter_year_calendar.f]
design/gecal_pkg.sv
design/gecal_if.sv
design/gecal_front.sv
design/gecal_queue.sv
design/gecal_back.sv
design/gregorian_easter_year_calendar.sv
sim/gregorian_easter_year_calendar_tb.sv
